// ----- sv/ptwal_pkg.sv -----
// ----------------------------------------------------------------------------
// ptwal_pkg
// Shared sizes, register indexes and stage types for the per-type window
// admission limiter.
// ----------------------------------------------------------------------------
package ptwal_pkg;

    // sizes
    localparam int WIN_MAX   = 1024;
    localparam int NUM_TYPES = 256;
    localparam int PTR_W     = $clog2(WIN_MAX);
    localparam int TYPE_W    = $clog2(NUM_TYPES);
    localparam int ITEM_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int DISC_W    = 32;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_TYPE = 1'b1;

    // one ring slot; live while keep is set and tok differs from the retire mark
    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic              keep;
        logic              tok;
    } t_slot;

    // clearing sweep after reset
    typedef struct packed {
        logic             busy;
        logic [PTR_W-1:0] addr;
    } t_clr;

    // request as captured at accept
    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [PTR_W-1:0]  ptr;
        logic [PTR_W-1:0]  leaving;
    } t_req;

    // resolved ring state for one request
    typedef struct packed {
        logic              self_ret;  // leaving slot is the arrival itself
        logic [TYPE_W-1:0] type_p;    // slot being overwritten
        logic              live_p;
        logic [TYPE_W-1:0] type_l;    // slot leaving the window
        logic              live_l;
        logic              tok;       // token for the new slot
        logic              rtok;      // retire mark for the leaving slot
    } t_view;

    typedef struct packed {
        t_req  req;
        t_view view;
    } t_stage;

endpackage

// ----- sv/per_type_window_admission_limiter.sv -----
// ----------------------------------------------------------------------------
// per_type_window_admission_limiter
// Keeps an arrival when its type has fewer than max_per_type kept items among
// the last window_len arrivals; reports the decision and a saturating
// discard total.
//
//   channel   signals                                  direction
//   input     i_in_valid / o_in_ready, i_item_type     request in
//   output    o_out_valid / i_out_ready, o_kept,
//             o_discards_so_far                        result out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data          write only
//
// One request per cycle sustained while results are taken; o_out_valid
// rises after its request passes the ring read at accept, the count read and
// the result register. The ring and count memories are read and written once
// per request, with in-flight writes forwarded, which sets the one-per-cycle figure.
// After reset a clearing pass sweeps the memories; o_in_ready stays low until
// it ends. Configuration writes are taken always.
// When the output is not taken, the two stages and the result register fill
// with three requests and then o_in_ready drops.
// ----------------------------------------------------------------------------
module per_type_window_admission_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ptwal_pkg::ITEM_W-1:0]        i_item_type,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_kept,
    output logic [ptwal_pkg::DISC_W-1:0]        o_discards_so_far,
    input  logic                                i_cfg_we,
    input  logic [ptwal_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptwal_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [ptwal_pkg::CFG_W-1:0]   r_win;
    logic [ptwal_pkg::CFG_W-1:0]   r_max;
    logic                          r_clr_busy;
    logic [ptwal_pkg::PTR_W-1:0]   r_clr_addr;
    logic [ptwal_pkg::PTR_W-1:0]   r_ptr;
    logic [ptwal_pkg::PTR_W-1:0]   n_ptr;
    logic                          r_a_valid;
    ptwal_pkg::t_req               r_a;
    logic                          r_b_valid;
    ptwal_pkg::t_stage             r_b;
    logic                          r_o_valid;
    logic                          r_o_kept;
    logic [ptwal_pkg::DISC_W-1:0]  r_o_disc;
    logic [ptwal_pkg::DISC_W-1:0]  r_disc;
    logic [ptwal_pkg::DISC_W-1:0]  n_disc;

    ptwal_pkg::t_clr               w_clr;
    ptwal_pkg::t_req               w_req;
    ptwal_pkg::t_view              w_view;
    logic [ptwal_pkg::PTR_W-1:0]   w_wm1;
    logic [ptwal_pkg::PTR_W:0]     w_wrap;
    logic [ptwal_pkg::PTR_W-1:0]   w_leaving;
    logic                          w_keep;
    logic                          w_o_free, w_b_adv, w_b_free, w_a_adv, w_a_free;
    logic                          w_in_fire;

    // pipeline flow
    assign w_o_free   = !r_o_valid || i_out_ready;
    assign w_b_adv    = r_b_valid && w_o_free;
    assign w_b_free   = !r_b_valid || w_b_adv;
    assign w_a_adv    = r_a_valid && w_b_free;
    assign w_a_free   = !r_a_valid || w_a_adv;
    assign o_in_ready = w_a_free && !r_clr_busy;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_clr = '{busy: r_clr_busy, addr: r_clr_addr};

    // window minus one, with zero taken as one and saturation at the ring size
    always_comb begin
        if (r_win == '0) begin
            w_wm1 = '0;
        end else if (r_win >= ptwal_pkg::CFG_W'(ptwal_pkg::WIN_MAX)) begin
            w_wm1 = ptwal_pkg::PTR_W'(ptwal_pkg::WIN_MAX - 1);
        end else begin
            w_wm1 = ptwal_pkg::PTR_W'(r_win - 1'b1);
        end
    end

    // slot leaving the window, modulo the ring size
    assign w_wrap = {1'b0, r_ptr} + (ptwal_pkg::PTR_W+1)'(ptwal_pkg::WIN_MAX) - {1'b0, w_wm1};
    assign w_leaving = (r_ptr >= w_wm1) ? (r_ptr - w_wm1) : w_wrap[ptwal_pkg::PTR_W-1:0];

    assign n_ptr = (r_ptr == ptwal_pkg::PTR_W'(ptwal_pkg::WIN_MAX - 1)) ? '0 : r_ptr + 1'b1;

    assign w_req = '{kind:    i_item_type[ptwal_pkg::TYPE_W-1:0],
                     ptr:     r_ptr,
                     leaving: w_leaving};

    // saturating discard total
    assign n_disc = (!w_keep && r_disc != '1) ? r_disc + 1'b1 : r_disc;

    ptwal_ring u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (w_clr),
        .i_rd_en      (w_in_fire),
        .i_rd_ptr     (r_ptr),
        .i_rd_leaving (w_leaving),
        .i_a          (r_a),
        .i_b          (r_b),
        .i_b_valid    (r_b_valid),
        .i_b_keep     (w_keep),
        .i_b_fire     (w_b_adv),
        .o_view       (w_view)
    );

    ptwal_counts u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_clr),
        .i_rd_en   (w_a_adv),
        .i_a       (r_a),
        .i_view    (w_view),
        .i_b       (r_b),
        .i_b_valid (r_b_valid),
        .i_b_fire  (w_b_adv),
        .i_max     (r_max),
        .o_keep    (w_keep)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= ptwal_pkg::CFG_W'(1);
            r_max <= ptwal_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptwal_pkg::CFG_WINDOW_LEN:   r_win <= i_cfg_data;
                ptwal_pkg::CFG_MAX_PER_TYPE: r_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clearing sweep, pointer, stage valids, discard total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_disc     <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == ptwal_pkg::PTR_W'(ptwal_pkg::WIN_MAX - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (w_in_fire) begin
                r_ptr <= n_ptr;
            end
            if (w_in_fire) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_adv) begin
                r_o_valid <= 1'b1;
                r_disc    <= n_disc;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a <= w_req;
        end
        if (w_a_adv) begin
            r_b <= '{req: r_a, view: w_view};
        end
        if (w_b_adv) begin
            r_o_kept <= w_keep;
            r_o_disc <= n_disc;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_kept            = r_o_kept;
    assign o_discards_so_far = r_o_disc;

    // no request enters while the memories are being swept
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("request taken during clearing pass");

    // the sweep ends only after the last ring slot
    a_clr_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == ptwal_pkg::PTR_W'(ptwal_pkg::WIN_MAX - 1))
        else $error("clearing pass ended early");

    // pointer steps by one slot per request
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && r_ptr != ptwal_pkg::PTR_W'(ptwal_pkg::WIN_MAX - 1)
            |=> r_ptr == $past(r_ptr) + 1'b1)
        else $error("ring pointer skipped");

    // discard total never wraps
    a_disc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_adv |=> r_disc >= $past(r_disc))
        else $error("discard total decreased");

endmodule

// ----- sv/ptwal_ring.sv -----
// ----------------------------------------------------------------------------
// ptwal_ring
// Ring of recent arrivals: slot memory written at the pointer, retire-mark
// memory written at the leaving slot, with forwarding of in-flight writes.
// ----------------------------------------------------------------------------
module ptwal_ring (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptwal_pkg::t_clr                     i_clr,
    input  logic                                i_rd_en,
    input  logic [ptwal_pkg::PTR_W-1:0]         i_rd_ptr,
    input  logic [ptwal_pkg::PTR_W-1:0]         i_rd_leaving,
    input  ptwal_pkg::t_req                     i_a,
    input  ptwal_pkg::t_stage                   i_b,
    input  logic                                i_b_valid,
    input  logic                                i_b_keep,
    input  logic                                i_b_fire,
    output ptwal_pkg::t_view                    o_view
);

    ptwal_pkg::t_slot mem_slot [ptwal_pkg::WIN_MAX];
    logic             mem_ret  [ptwal_pkg::WIN_MAX];

    ptwal_pkg::t_slot               r_rd_slot_p;
    ptwal_pkg::t_slot               r_rd_slot_l;
    logic                           r_rd_ret_p;
    logic                           r_rd_ret_l;

    logic                           r_lw_valid;
    logic [ptwal_pkg::PTR_W-1:0]    r_lw_addr;
    ptwal_pkg::t_slot               r_lw_slot;
    logic                           r_lr_valid;
    logic [ptwal_pkg::PTR_W-1:0]    r_lr_addr;
    logic                           r_lr_ret;

    ptwal_pkg::t_slot               w_wr_slot;
    ptwal_pkg::t_slot               w_slot_p;
    ptwal_pkg::t_slot               w_slot_l;
    logic                           w_ret_p;
    logic                           w_ret_l;

    // slot written by the request in the second stage
    assign w_wr_slot = '{kind: i_b.req.kind, keep: i_b_keep, tok: i_b.view.tok};

    // memories: clearing sweep or stage write, reads at accept
    always_ff @(posedge i_clk) begin
        if (i_clr.busy) begin
            mem_slot[i_clr.addr] <= '0;
            mem_ret[i_clr.addr]  <= 1'b0;
        end else if (i_b_fire) begin
            mem_slot[i_b.req.ptr]    <= w_wr_slot;
            mem_ret[i_b.req.leaving] <= i_b.view.rtok;
        end
        if (i_rd_en) begin
            r_rd_slot_p <= mem_slot[i_rd_ptr];
            r_rd_slot_l <= mem_slot[i_rd_leaving];
            r_rd_ret_p  <= mem_ret[i_rd_ptr];
            r_rd_ret_l  <= mem_ret[i_rd_leaving];
        end
        if (i_b_fire) begin
            r_lw_addr <= i_b.req.ptr;
            r_lw_slot <= w_wr_slot;
            r_lr_addr <= i_b.req.leaving;
            r_lr_ret  <= i_b.view.rtok;
        end
    end

    // last-write valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
            r_lr_valid <= 1'b0;
        end else if (i_b_fire) begin
            r_lw_valid <= 1'b1;
            r_lr_valid <= 1'b1;
        end
    end

    // forward: newest request first, then the last write, then memory
    always_comb begin
        if (i_b_valid && i_b.req.ptr == i_a.ptr) begin
            w_slot_p = w_wr_slot;
        end else if (r_lw_valid && r_lw_addr == i_a.ptr) begin
            w_slot_p = r_lw_slot;
        end else begin
            w_slot_p = r_rd_slot_p;
        end
        if (i_b_valid && i_b.req.ptr == i_a.leaving) begin
            w_slot_l = w_wr_slot;
        end else if (r_lw_valid && r_lw_addr == i_a.leaving) begin
            w_slot_l = r_lw_slot;
        end else begin
            w_slot_l = r_rd_slot_l;
        end
        if (i_b_valid && i_b.req.leaving == i_a.ptr) begin
            w_ret_p = i_b.view.rtok;
        end else if (r_lr_valid && r_lr_addr == i_a.ptr) begin
            w_ret_p = r_lr_ret;
        end else begin
            w_ret_p = r_rd_ret_p;
        end
        if (i_b_valid && i_b.req.leaving == i_a.leaving) begin
            w_ret_l = i_b.view.rtok;
        end else if (r_lr_valid && r_lr_addr == i_a.leaving) begin
            w_ret_l = r_lr_ret;
        end else begin
            w_ret_l = r_rd_ret_l;
        end
    end

    // resolved view; a self-retire marks the new slot with its own token
    always_comb begin
        o_view.self_ret = (i_a.ptr == i_a.leaving);
        o_view.type_p   = w_slot_p.kind;
        o_view.live_p   = w_slot_p.keep && (w_slot_p.tok != w_ret_p);
        o_view.type_l   = w_slot_l.kind;
        o_view.live_l   = w_slot_l.keep && (w_slot_l.tok != w_ret_l);
        o_view.tok      = ~w_ret_p;
        o_view.rtok     = o_view.self_ret ? ~w_ret_p : w_slot_l.tok;
    end

    // a slot retired in its own step must read back as no longer live
    a_self_retired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_b_fire && (i_b.req.leaving == i_b.req.ptr) |=> r_lr_ret == r_lw_slot.tok)
        else $error("self-retired slot still live");

endmodule

// ----- sv/ptwal_counts.sv -----
// ----------------------------------------------------------------------------
// ptwal_counts
// Per-type kept counts, held as one admit counter and two retire counters
// per type so that each memory takes one write per request.
// ----------------------------------------------------------------------------
module ptwal_counts (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptwal_pkg::t_clr                 i_clr,
    input  logic                            i_rd_en,
    input  ptwal_pkg::t_req                 i_a,
    input  ptwal_pkg::t_view                i_view,
    input  ptwal_pkg::t_stage               i_b,
    input  logic                            i_b_valid,
    input  logic                            i_b_fire,
    input  logic [ptwal_pkg::CFG_W-1:0]     i_max,
    output logic                            o_keep
);

    logic [ptwal_pkg::CNT_W-1:0] mem_inc [ptwal_pkg::NUM_TYPES];
    logic [ptwal_pkg::CNT_W-1:0] mem_da  [ptwal_pkg::NUM_TYPES];
    logic [ptwal_pkg::CNT_W-1:0] mem_db  [ptwal_pkg::NUM_TYPES];

    logic [ptwal_pkg::CNT_W-1:0]  r_inc_t, r_da_t, r_da_p, r_db_t, r_db_l;

    logic                         r_li_valid, r_la_valid, r_lb_valid;
    logic [ptwal_pkg::TYPE_W-1:0] r_li_addr,  r_la_addr,  r_lb_addr;
    logic [ptwal_pkg::CNT_W-1:0]  r_li_data,  r_la_data,  r_lb_data;

    logic [ptwal_pkg::TYPE_W-1:0] w_rd_tl;
    logic [ptwal_pkg::TYPE_W-1:0] w_b_tl;
    logic [ptwal_pkg::TYPE_W-1:0] w_clr_addr;
    logic [ptwal_pkg::CNT_W-1:0]  w_inc_t, w_da_t, w_da_p, w_db_t, w_db_l;
    logic [ptwal_pkg::CNT_W-1:0]  w_count;
    logic                         w_we_inc, w_we_da, w_we_db;

    function automatic logic [ptwal_pkg::CNT_W-1:0] fwd(
        input logic                         v,
        input logic [ptwal_pkg::TYPE_W-1:0] wa,
        input logic [ptwal_pkg::CNT_W-1:0]  wd,
        input logic [ptwal_pkg::TYPE_W-1:0] ra,
        input logic [ptwal_pkg::CNT_W-1:0]  rd
    );
        return (v && wa == ra) ? wd : rd;
    endfunction

    // leaving type: the arrival itself on a one-slot window
    assign w_rd_tl    = i_view.self_ret ? i_a.kind : i_view.type_l;
    assign w_b_tl     = i_b.view.self_ret ? i_b.req.kind : i_b.view.type_l;
    assign w_clr_addr = i_clr.addr[ptwal_pkg::TYPE_W-1:0];

    // forwarded counters, count before this request's retires
    assign w_inc_t = fwd(r_li_valid, r_li_addr, r_li_data, i_b.req.kind, r_inc_t);
    assign w_da_t  = fwd(r_la_valid, r_la_addr, r_la_data, i_b.req.kind, r_da_t);
    assign w_da_p  = fwd(r_la_valid, r_la_addr, r_la_data, i_b.view.type_p, r_da_p);
    assign w_db_t  = fwd(r_lb_valid, r_lb_addr, r_lb_data, i_b.req.kind, r_db_t);
    assign w_db_l  = fwd(r_lb_valid, r_lb_addr, r_lb_data, w_b_tl, r_db_l);
    assign w_count = w_inc_t - w_da_t - w_db_t;
    assign o_keep  = (w_count < i_max);

    assign w_we_inc = i_b_fire && o_keep;
    assign w_we_da  = i_b_fire && i_b.view.live_p;
    assign w_we_db  = i_b_fire && (i_b.view.self_ret ? o_keep : i_b.view.live_l);

    // memories and last-write payload
    always_ff @(posedge i_clk) begin
        if (i_clr.busy) begin
            mem_inc[w_clr_addr] <= '0;
            mem_da[w_clr_addr]  <= '0;
            mem_db[w_clr_addr]  <= '0;
        end else begin
            if (w_we_inc) begin
                mem_inc[i_b.req.kind] <= w_inc_t + 1'b1;
            end
            if (w_we_da) begin
                mem_da[i_b.view.type_p] <= w_da_p + 1'b1;
            end
            if (w_we_db) begin
                mem_db[w_b_tl] <= w_db_l + 1'b1;
            end
        end
        if (i_rd_en) begin
            r_inc_t <= mem_inc[i_a.kind];
            r_da_t  <= mem_da[i_a.kind];
            r_da_p  <= mem_da[i_view.type_p];
            r_db_t  <= mem_db[i_a.kind];
            r_db_l  <= mem_db[w_rd_tl];
        end
        if (w_we_inc) begin
            r_li_addr <= i_b.req.kind;
            r_li_data <= w_inc_t + 1'b1;
        end
        if (w_we_da) begin
            r_la_addr <= i_b.view.type_p;
            r_la_data <= w_da_p + 1'b1;
        end
        if (w_we_db) begin
            r_lb_addr <= w_b_tl;
            r_lb_data <= w_db_l + 1'b1;
        end
    end

    // last-write valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_li_valid <= 1'b0;
            r_la_valid <= 1'b0;
            r_lb_valid <= 1'b0;
        end else begin
            if (w_we_inc) begin
                r_li_valid <= 1'b1;
            end
            if (w_we_da) begin
                r_la_valid <= 1'b1;
            end
            if (w_we_db) begin
                r_lb_valid <= 1'b1;
            end
        end
    end

    // a type can never hold more kept items than the ring has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_b_valid |-> w_count <= ptwal_pkg::CNT_W'(ptwal_pkg::WIN_MAX))
        else $error("per-type count exceeds ring size");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-type window admission limiter. Requests
// are driven on the valid/ready input channel. A scoreboard predicts each
// keep decision and the saturating discard total from its own copy of the
// ring, the per-type counts and the configuration, then checks every result
// in order. The run covers a directed part, random phases over several
// window and limit settings, and several idling patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
    localparam int HOLD_PHASE = 1;      // phase in which the receiver holds off
    localparam int HOLD_LEN   = 300;

    typedef struct {
        bit                         kept;
        bit [ptwal_pkg::DISC_W-1:0] discards;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Scoreboard: window admission predictor plus in-order verdict check
    // ------------------------------------------------------------------------
    class t_admission_scoreboard;
        int unsigned                kept_per_type[ptwal_pkg::NUM_TYPES];
        bit [ptwal_pkg::ITEM_W-1:0] slot_type[ptwal_pkg::WIN_MAX];
        bit                         slot_live[ptwal_pkg::WIN_MAX];
        int unsigned                next_slot;
        bit [ptwal_pkg::DISC_W-1:0] discard_count;
        bit [ptwal_pkg::CFG_W-1:0]  window_len;
        bit [ptwal_pkg::CFG_W-1:0]  type_cap;
        t_verdict                   pending_verdicts[$];
        int unsigned                failures;

        function new();
            foreach (kept_per_type[i]) kept_per_type[i] = 0;
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
                slot_type[i] = '0;
            end
            next_slot     = 0;
            discard_count = '0;
            window_len    = ptwal_pkg::CFG_W'(1);
            type_cap      = ptwal_pkg::CFG_W'(1);
            failures      = 0;
        endfunction

        // a counted slot gives back its type's count once, then is cleared
        function void drop_slot(int unsigned slot);
            int unsigned k;
            if (slot_live[slot]) begin
                k = slot_type[slot] % ptwal_pkg::NUM_TYPES;
                if (kept_per_type[k] > 0) kept_per_type[k]--;
                slot_live[slot] = 1'b0;
            end
        endfunction

        function void set_register(logic [ptwal_pkg::CFG_IDX_W-1:0] idx,
                                   bit [ptwal_pkg::CFG_W-1:0] val);
            if (idx == ptwal_pkg::CFG_WINDOW_LEN) window_len = val;
            else if (idx == ptwal_pkg::CFG_MAX_PER_TYPE) type_cap = val;
        endfunction

        // predict the verdict for one accepted request
        function void note_arrival(bit [ptwal_pkg::ITEM_W-1:0] item);
            int unsigned k, w, p, leaving;
            t_verdict    v;
            k = item % ptwal_pkg::NUM_TYPES;
            w = 32'(window_len);
            if (w == 0) w = 1;
            if (w > ptwal_pkg::WIN_MAX) w = ptwal_pkg::WIN_MAX;
            p = next_slot;
            v.kept = kept_per_type[k] < type_cap;
            if (v.kept) begin
                if (kept_per_type[k] < (1 << ptwal_pkg::CNT_W) - 1) kept_per_type[k]++;
            end else if (discard_count != '1) begin
                discard_count++;
            end
            // overwritten slot retires first, then the one leaving the window
            drop_slot(p);
            slot_type[p] = item;
            slot_live[p] = v.kept;
            leaving = (p + ptwal_pkg::WIN_MAX - (w - 1)) % ptwal_pkg::WIN_MAX;
            drop_slot(leaving);
            next_slot = (p + 1) % ptwal_pkg::WIN_MAX;
            v.discards = discard_count;
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(bit kept, bit [ptwal_pkg::DISC_W-1:0] discards);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                $error("result with no request outstanding: kept %0d discards %0d",
                       kept, discards);
                failures++;
            end else begin
                v = pending_verdicts.pop_front();
                if (kept !== v.kept) begin
                    $error("kept: expected %0d, got %0d", v.kept, kept);
                    failures++;
                end
                if (discards !== v.discards) begin
                    $error("discards_so_far: expected %0d, got %0d", v.discards, discards);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [ptwal_pkg::ITEM_W-1:0]    i_item_type;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_kept;
    logic [ptwal_pkg::DISC_W-1:0]    o_discards_so_far;
    logic                            i_cfg_we;
    logic [ptwal_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ptwal_pkg::CFG_W-1:0]     i_cfg_data;

    t_admission_scoreboard sb;
    int                    tx_idle_pct;
    int                    rx_stall_pct;
    int                    phase_no;

    per_type_window_admission_limiter DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_item_type       (i_item_type),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kept            (o_kept),
        .o_discards_so_far (o_discards_so_far),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off to back up the block
    initial begin
        int hold_left;
        bit held;
        hold_left   = 0;
        held        = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && phase_no == HOLD_PHASE) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // check every result taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_verdict(o_kept, o_discards_so_far);
    end

    // watchdog on cycles with no handshake on either channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one request; called and returns at a falling edge
    task automatic send_arrival(input logic [ptwal_pkg::ITEM_W-1:0] item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_item_type = item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_arrival(item);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ptwal_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ptwal_pkg::CFG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.set_register(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // stop offering, drain every outstanding result, then reconfigure
    task automatic drain_and_configure(input int win, input int cap);
        i_in_valid = 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        write_register(ptwal_pkg::CFG_WINDOW_LEN, win[ptwal_pkg::CFG_W-1:0]);
        write_register(ptwal_pkg::CFG_MAX_PER_TYPE, cap[ptwal_pkg::CFG_W-1:0]);
    endtask

    // random phase: mostly a few hot types, some over the whole type range
    task automatic run_phase(input int win, input int cap, input int span,
                             input int tx, input int rx, input int count);
        logic [ptwal_pkg::ITEM_W-1:0] item;
        drain_and_configure(win, cap);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        phase_no++;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                item = ptwal_pkg::ITEM_W'($urandom_range(0, 255));
            end else begin
                item = ptwal_pkg::ITEM_W'($urandom_range(0, span));
            end
            send_arrival(item);
        end
    endtask

    // main sequence
    initial begin
        sb           = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        phase_no     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_item_type  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = ptwal_pkg::CFG_WINDOW_LEN;
        i_cfg_data   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: window of one, so each arrival retires itself
        send_arrival(8'd0);
        send_arrival(8'd255);
        send_arrival(8'd0);
        send_arrival(8'd0);

        // short window, one per type: repeats are discarded until aged out
        drain_and_configure(3, 1);
        send_arrival(8'd5);
        send_arrival(8'd5);
        send_arrival(8'd5);
        send_arrival(8'd5);
        send_arrival(8'd7);
        send_arrival(8'd5);

        // window above the ring size saturates
        drain_and_configure(2047, 2);
        send_arrival(8'd8);
        send_arrival(8'd8);
        send_arrival(8'd8);
        send_arrival(8'd170);
        send_arrival(8'd85);

        // limit zero: everything discarded
        drain_and_configure(1024, 0);
        send_arrival(8'd0);
        send_arrival(8'd255);
        send_arrival(8'd1);

        // window zero acts as one, top limit
        drain_and_configure(0, 2047);
        send_arrival(8'd3);
        send_arrival(8'd3);
        send_arrival(8'd3);

        // random phases: the pipeline is drained before each window and limit change
        run_phase(16, 2, 7, 0, 0, 175);
        run_phase(1024, 3, 15, 85, 0, 175);
        run_phase(5, 1, 3, 0, 85, 175);
        run_phase(64, 1024, 1, 17, 17, 175);
        run_phase(64, 1, 1, 0, 0, 175);      // limit now below live counts
        run_phase(2047, 0, 255, 85, 0, 175);
        run_phase(0, 2047, 255, 0, 85, 175);
        run_phase(200, 4, 11, 17, 17, 175);

        // drain and let the pipeline settle
        i_in_valid = 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
